// ===== hdl/psf_pkg.sv =====
// Shared widths, queue entry type and digit helpers for the pump display frame block.
`timescale 1ns / 1ps
package psf_pkg;

	localparam int VAL_W      = 27;
	localparam int BIN_W      = 2 * VAL_W;
	localparam int STEP_BITS  = 3;
	localparam int CONV_STEPS = BIN_W / STEP_BITS;
	localparam int CNT_W      = 5;
	localparam int PV_DIG     = 9;
	localparam int PD_DIG     = 17;
	localparam int DROP_DIG   = 3;
	localparam int TOT_DIG    = PD_DIG - DROP_DIG;
	localparam int PV_BCD_W   = 4 * PV_DIG;
	localparam int PD_BCD_W   = 4 * PD_DIG;
	localparam int TOT_BCD_W  = 4 * TOT_DIG;

	localparam logic [VAL_W-1:0] PRICE_RESET = 27'd31300;

	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] DP_BIT    = 8'h80;

	localparam logic [3:0] PRICE_DP = 4'd2;
	localparam logic [3:0] VOL_DP   = 4'd3;
	localparam logic [3:0] TOT_DP   = 4'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PUSH
	} psf_state_t;

	typedef struct packed {
		logic [PV_BCD_W-1:0]  price_bcd;
		logic [PV_BCD_W-1:0]  vol_bcd;
		logic [TOT_BCD_W-1:0] tot_bcd;
	} psf_entry_t;

	function automatic logic [PD_BCD_W-1:0] dd_bit(input logic [PD_BCD_W-1:0] bcd,
	                                               input logic b);
		logic [PD_BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < PD_DIG; i++) begin
			if (adj[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
			end
		end
		return {adj[PD_BCD_W-2:0], b};
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0:    code = 8'h3F;
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h5B;
			4'd3:    code = 8'h4F;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'h6D;
			4'd6:    code = 8'h7D;
			4'd7:    code = 8'h47;
			4'd8:    code = 8'h7F;
			4'd9:    code = 8'h6F;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/pump_display_segment_frame.sv =====
// Top level of the pump display frame block: price register, converter, queue and serialiser.
// Usage:
//   Configuration: write unit_price_cents with cfg_valid; cfg_ready is always high.
//   Input: one request is a volume_milli value, taken when in_valid is high and in_stall low.
//   Output: each request yields a frame of min(FRAME_BYTES, 3*DIGITS) segment bytes,
//   price digits, then volume digits, then total digits, least significant first, with
//   position counting up from 0 and last set on the final byte.
// Path from the accepting edge to out_valid on the first byte: product load, conversion at
//   3 bits per cycle, queue write, queue read, output register.
// The serialiser emits one byte per cycle while the output is not stalled; the input
//   register can take a new request while the previous one is still converting.
// A two-entry queue holds converted requests, so the front keeps converting while the
//   output is stalled; in_stall rises once the input register is occupied.
// When out_stall is high the current byte is held and the serialiser pauses.
// Reset: the queue and serialiser empty, the price returns to 31300 and no byte is shown.
`timescale 1ns / 1ps
module pump_display_segment_frame #(
	parameter int DIGITS      = 8,
	parameter int FRAME_BYTES = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [psf_pkg::VAL_W-1:0] unit_price_cents,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [psf_pkg::VAL_W-1:0] volume_milli,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                segment_byte,
	output logic [4:0]                position,
	output logic                      last
);
	import psf_pkg::*;

	logic       push_valid, push_ready;
	logic       pop_valid, pop_ready;
	psf_entry_t push_entry, pop_entry;

	assign cfg_ready = 1'b1;

	psf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.volume_milli     (volume_milli),
		.cfg_valid        (cfg_valid),
		.unit_price_cents (unit_price_cents),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_entry       (push_entry)
	);

	psf_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	psf_back #(
		.DIGITS      (DIGITS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_byte (segment_byte),
		.position     (position),
		.last         (last)
	);

endmodule

// ===== hdl/psf_front.sv =====
// Front end: input register, price register, product and shift-add-3 decimal conversion.
`timescale 1ns / 1ps
module psf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [psf_pkg::VAL_W-1:0] volume_milli,
	input  logic                     cfg_valid,
	input  logic [psf_pkg::VAL_W-1:0] unit_price_cents,
	output logic                     push_valid,
	input  logic                     push_ready,
	output psf_pkg::psf_entry_t      push_entry
);
	import psf_pkg::*;

	psf_state_t          state_q, state_d;
	logic                full_q;
	logic [VAL_W-1:0]    vol_q;
	logic [VAL_W-1:0]    price_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BIN_W-1:0]    bin_pr_q, bin_vo_q, bin_pd_q;
	logic [PV_BCD_W-1:0] bcd_pr_q, bcd_vo_q;
	logic [PD_BCD_W-1:0] bcd_pd_q;
	logic [PD_BCD_W-1:0] pr_n, vo_n, pd_n;
	logic [BIN_W-1:0]    prod;
	logic                load, conv_en, conv_done;

	assign in_stall  = full_q;
	assign prod      = BIN_W'(vol_q) * BIN_W'(price_q);
	assign conv_done = cnt_q == CNT_W'(CONV_STEPS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (full_q) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (push_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load       = 1'b0;
		conv_en    = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: load       = full_q;
			ST_CONV: conv_en    = 1'b1;
			ST_PUSH: push_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		pr_n = PD_BCD_W'(bcd_pr_q);
		vo_n = PD_BCD_W'(bcd_vo_q);
		pd_n = bcd_pd_q;
		for (int j = 0; j < STEP_BITS; j++) begin
			pr_n = dd_bit(pr_n, bin_pr_q[BIN_W-1-j]);
			vo_n = dd_bit(vo_n, bin_vo_q[BIN_W-1-j]);
			pd_n = dd_bit(pd_n, bin_pd_q[BIN_W-1-j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			full_q  <= 1'b0;
			cnt_q   <= '0;
			price_q <= PRICE_RESET;
		end else begin
			state_q <= state_d;
			if (in_valid && !full_q) begin
				full_q <= 1'b1;
			end else if (load) begin
				full_q <= 1'b0;
			end
			if (load) begin
				cnt_q <= '0;
			end else if (conv_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cfg_valid) price_q <= unit_price_cents;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !full_q) vol_q <= volume_milli;
		if (load) begin
			bin_pr_q <= BIN_W'(price_q);
			bin_vo_q <= BIN_W'(vol_q);
			bin_pd_q <= prod;
			bcd_pr_q <= '0;
			bcd_vo_q <= '0;
			bcd_pd_q <= '0;
		end else if (conv_en) begin
			bin_pr_q <= {bin_pr_q[BIN_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
			bin_vo_q <= {bin_vo_q[BIN_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
			bin_pd_q <= {bin_pd_q[BIN_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
			bcd_pr_q <= pr_n[PV_BCD_W-1:0];
			bcd_vo_q <= vo_n[PV_BCD_W-1:0];
			bcd_pd_q <= pd_n;
		end
	end

	assign push_entry.price_bcd = bcd_pr_q;
	assign push_entry.vol_bcd   = bcd_vo_q;
	assign push_entry.tot_bcd   = bcd_pd_q[PD_BCD_W-1:4*DROP_DIG];

endmodule

// ===== hdl/psf_fifo.sv =====
// Two-entry queue of converted digit sets between front and back.
`timescale 1ns / 1ps
module psf_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  psf_pkg::psf_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output psf_pkg::psf_entry_t pop_entry
);
	import psf_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W2 = $clog2(DEPTH + 1);

	psf_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W2-1:0]  cnt_q;
	logic               push, pop;

	assign push_ready = cnt_q != CNT_W2'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop)  rd_q <= rd_q + PTR_W'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W2'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W2'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W2'(DEPTH))
		else $error("queue count past depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with pointers apart");

endmodule

// ===== hdl/psf_back.sv =====
// Back end: walks one digit set and emits the frame one segment byte per cycle unless the output is stalled.
`timescale 1ns / 1ps
module psf_back #(
	parameter int DIGITS      = 8,
	parameter int FRAME_BYTES = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  psf_pkg::psf_entry_t pop_entry,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          segment_byte,
	output logic [4:0]          position,
	output logic                last
);
	import psf_pkg::*;

	localparam int N  = (FRAME_BYTES < 3 * DIGITS) ? FRAME_BYTES : 3 * DIGITS;
	localparam int DW = $clog2(DIGITS);
	localparam int PW = $clog2(N);
	localparam logic [5:0] LAST_POS = 6'(N - 1);

	localparam logic [1:0] SEL_PRICE = 2'd0;
	localparam logic [1:0] SEL_VOL   = 2'd1;
	localparam logic [1:0] SEL_TOT   = 2'd2;

	psf_entry_t           entry_q;
	logic                 busy_q;
	logic [1:0]           sel_q;
	logic [DW-1:0]        dig_q;
	logic [PW-1:0]        pos_q;
	logic                 out_valid_q;
	logic [7:0]           seg_q;
	logic [4:0]           position_q;
	logic                 last_q;
	logic                 adv, is_last, pop;
	logic [TOT_BCD_W-1:0] val, rest;
	logic [3:0]           dpp;
	logic [7:0]           seg_d;
	logic [5:0]           pos_ext;

	assign adv       = busy_q && (!out_valid_q || !out_stall);
	assign is_last   = pos_q == PW'(N - 1);
	assign pop_ready = !busy_q || (adv && is_last);
	assign pop       = pop_valid && pop_ready;
	assign pos_ext   = 6'(pos_q);

	always_comb begin
		case (sel_q)
			SEL_PRICE: begin
				val = TOT_BCD_W'(entry_q.price_bcd);
				dpp = PRICE_DP;
			end
			SEL_VOL: begin
				val = TOT_BCD_W'(entry_q.vol_bcd);
				dpp = VOL_DP;
			end
			default: begin
				val = entry_q.tot_bcd;
				dpp = TOT_DP;
			end
		endcase
		rest = val >> {dig_q, 2'b00};
		if (rest == '0 && dig_q != '0) begin
			seg_d = SEG_BLANK;
		end else begin
			seg_d = seg_of(rest[3:0]);
			if (4'(dig_q) == dpp) seg_d = seg_d | DP_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sel_q       <= SEL_PRICE;
			dig_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (adv && is_last) begin
				busy_q <= 1'b0;
			end
			if (pop) begin
				sel_q <= SEL_PRICE;
				dig_q <= '0;
				pos_q <= '0;
			end else if (adv) begin
				pos_q <= pos_q + PW'(1);
				if (dig_q == DW'(DIGITS - 1)) begin
					dig_q <= '0;
					sel_q <= sel_q + 2'd1;
				end else begin
					dig_q <= dig_q + DW'(1);
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) entry_q <= pop_entry;
		if (adv) begin
			seg_q      <= seg_d;
			position_q <= pos_ext[4:0];
			last_q     <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign segment_byte = seg_q;
	assign position     = position_q;
	assign last         = last_q;

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (position_q == LAST_POS[4:0]))
		else $error("last flag away from final frame position");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_last) |=> (!busy_q || (pos_q == '0 && dig_q == '0 && sel_q == SEL_PRICE)))
		else $error("new frame does not start at position zero");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (sel_q == SEL_PRICE || sel_q == SEL_VOL || sel_q == SEL_TOT))
		else $error("value select past total");

endmodule

// ===== bench/psf_frame_checker.sv =====
// Frame checker: predicts the 24 segment bytes of each volume request and compares the output.
`timescale 1ns / 1ps
module psf_frame_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [psf_pkg::VAL_W-1:0] unit_price_cents,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [psf_pkg::VAL_W-1:0] volume_milli,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [7:0]                segment_byte,
	input  logic [4:0]                position,
	input  logic                      last,
	output int                        fail_count,
	output int                        pending_bytes
);

	import psf_pkg::*;

	localparam int NUM_DIGITS = 8;
	localparam int FRAME_LEN  = 3 * NUM_DIGITS;

	localparam logic [7:0] SEG_CODE [0:9] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h47, 8'h7F, 8'h6F
	};

	typedef logic [NUM_DIGITS-1:0][7:0] digit_row_t;

	typedef struct packed {
		logic [7:0] seg;
		logic [4:0] pos;
		logic       last;
	} frame_byte_t;

	frame_byte_t      expected_bytes [$];
	logic [VAL_W-1:0] price_copy;

	function automatic digit_row_t encode_digits(input logic [63:0] value,
	                                             input logic [3:0] dp_digit);
		digit_row_t row;
		logic [63:0] rest;
		logic [7:0]  code;
		rest = value;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (rest != 64'd0) begin
				code = SEG_CODE[rest % 64'd10];
				rest = rest / 64'd10;
			end else if (i == 0) begin
				code = SEG_CODE[0];
			end else begin
				code = SEG_BLANK;
			end
			if (code != SEG_BLANK && i == int'(dp_digit)) begin
				code = code | DP_BIT;
			end
			row[i] = code;
		end
		return row;
	endfunction

	function automatic void predict_frame(input logic [VAL_W-1:0] vol);
		logic [63:0] total;
		digit_row_t  price_row;
		digit_row_t  vol_row;
		digit_row_t  total_row;
		frame_byte_t fb;
		total     = (64'(vol) * 64'(price_copy)) / 64'd1000;
		price_row = encode_digits(64'(price_copy), PRICE_DP);
		vol_row   = encode_digits(64'(vol), VOL_DP);
		total_row = encode_digits(total, TOT_DP);
		for (int k = 0; k < FRAME_LEN; k++) begin
			if (k < NUM_DIGITS) begin
				fb.seg = price_row[k];
			end else if (k < 2 * NUM_DIGITS) begin
				fb.seg = vol_row[k - NUM_DIGITS];
			end else begin
				fb.seg = total_row[k - 2 * NUM_DIGITS];
			end
			fb.pos  = 5'(k);
			fb.last = (k == FRAME_LEN - 1);
			expected_bytes.push_back(fb);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			price_copy = PRICE_RESET;
			expected_bytes.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected byte seg %h pos %0d last %b",
						         $realtime, segment_byte, position, last);
					end
				end else begin
					want = expected_bytes.pop_front();
					if (segment_byte !== want.seg || position !== want.pos ||
					    last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch expected seg %h pos %0d last %b, got seg %h pos %0d last %b",
							         $realtime, want.seg, want.pos, want.last,
							         segment_byte, position, last);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				price_copy = unit_price_cents;
			end
			if (in_valid && !in_stall) begin
				predict_frame(volume_milli);
			end
		end
		pending_bytes = expected_bytes.size();
	end

endmodule

// ===== bench/pump_display_segment_frame_tb.sv =====
// Testbench top for the pump display frame block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module pump_display_segment_frame_tb;

	import psf_pkg::*;

	localparam logic [VAL_W-1:0] VOL_MAX   = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] SPEC_MAX  = 27'd99999999;
	localparam int               LONG_HOLD = 300;
	localparam int               RAND_PHASES     = 6;
	localparam int               ITEMS_PER_PHASE = 60;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [VAL_W-1:0] unit_price_cents;
	logic             in_valid;
	logic             in_stall;
	logic [VAL_W-1:0] volume_milli;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       segment_byte;
	logic [4:0]       position;
	logic             last;
	int               fail_count;
	int               pending_bytes;
	bit               hold_go;
	bit               hold_done;

	pump_display_segment_frame uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.unit_price_cents (unit_price_cents),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.volume_milli     (volume_milli),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.segment_byte     (segment_byte),
		.position         (position),
		.last             (last)
	);

	psf_frame_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.unit_price_cents (unit_price_cents),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.volume_milli     (volume_milli),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.segment_byte     (segment_byte),
		.position         (position),
		.last             (last),
		.fail_count       (fail_count),
		.pending_bytes    (pending_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VAL_W-1:0] pick_volume();
		int r;
		int k;
		int p;
		r = $urandom_range(0, 99);
		if (r < 10) return VAL_W'($urandom_range(0, 9));
		if (r < 25) return VAL_W'($urandom_range(0, 9999));
		if (r < 35) begin
			k = $urandom_range(0, 8);
			p = 1;
			repeat (k) p = p * 10;
			return $urandom_range(0, 1) ? VAL_W'(p) : VAL_W'(p - 1);
		end
		if (r < 85) return VAL_W'($urandom_range(0, int'(SPEC_MAX)));
		return VAL_W'($urandom());
	endfunction

	task automatic send_volume(input logic [VAL_W-1:0] vol, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		volume_milli <= vol;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_price(input logic [VAL_W-1:0] price);
		cfg_valid        <= 1'b1;
		unit_price_cents <= price;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_frames();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes != 0) @(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off to fill the block
	initial begin : receiver
		int stall_len;
		int run_len;
		out_stall = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				stall_len = pick_gap();
				run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				                                        : $urandom_range(1, 4);
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
					out_stall <= 1'b0;
				end
				repeat (run_len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [VAL_W-1:0] price_pick;
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		unit_price_cents = '0;
		in_valid         = 1'b0;
		volume_milli     = '0;
		hold_go          = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset price: zero, small, digit carries, blanking edges, overflow
		send_volume(27'd0, pick_gap());
		send_volume(27'd1, pick_gap());
		send_volume(27'd9, pick_gap());
		send_volume(27'd10, pick_gap());
		send_volume(27'd999, pick_gap());
		send_volume(27'd1000, pick_gap());
		send_volume(27'd12345678, pick_gap());
		send_volume(SPEC_MAX, pick_gap());
		send_volume(27'd100000000, pick_gap());
		send_volume(VOL_MAX, pick_gap());

		drain_frames();
		write_price(27'd0);
		send_volume(27'd0, pick_gap());
		send_volume(27'd55555555, pick_gap());
		send_volume(VOL_MAX, pick_gap());

		drain_frames();
		write_price(VOL_MAX);
		send_volume(VOL_MAX, pick_gap());
		send_volume(27'd1, pick_gap());
		send_volume(27'd7, pick_gap());

		drain_frames();
		write_price(SPEC_MAX);
		send_volume(SPEC_MAX, pick_gap());
		send_volume(27'd100, pick_gap());

		drain_frames();
		write_price(27'd1);
		send_volume(27'd999, pick_gap());
		send_volume(27'd1000, pick_gap());
		send_volume(27'd1999, pick_gap());

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain_frames();
			case (ph)
				0:       price_pick = VAL_W'($urandom_range(0, int'(SPEC_MAX)));
				1:       price_pick = VAL_W'($urandom_range(1, 999));
				2:       price_pick = VAL_W'($urandom());
				3:       price_pick = SPEC_MAX;
				4:       price_pick = VAL_W'($urandom_range(0, int'(SPEC_MAX)));
				default: price_pick = PRICE_RESET;
			endcase
			write_price(price_pick);
			if (ph == 1) hold_go = 1'b1;
			repeat (ITEMS_PER_PHASE) send_volume(pick_volume(), pick_gap());
		end

		drain_frames();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
